>>> design/vict_pkg.sv
// ----------------------------------------------------------------------------
// vict_pkg
// Shared constants, register indices and helpers for the voxel-in-cylinder
// test pipeline.
// ----------------------------------------------------------------------------
package vict_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 4;
    localparam int RADIUS_BITS       = 15;
    localparam int SLACK_BITS        = 16;
    // squared lengths are scaled up by 2^SCALE_SHIFT to meet the slack format
    localparam int SCALE_SHIFT       = 8;
    localparam int CFG_IDX_BITS      = 3;

    localparam int FRONT_STAGES = 4;
    localparam int MUL_STAGES   = 3;
    localparam int BACK_STAGES  = 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + MUL_STAGES + BACK_STAGES;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_START_Z  = 3'd2,
        REG_FINISH_X = 3'd3,
        REG_FINISH_Y = 3'd4,
        REG_FINISH_Z = 3'd5,
        REG_RADIUS   = 3'd6,
        REG_SLACK    = 3'd7
    } t_cfg_idx;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> design/vict_mul.sv
// ----------------------------------------------------------------------------
// vict_mul
// Unsigned multiplier split into four half-width partial products,
// three register stages, advancing on enable.
// ----------------------------------------------------------------------------
module vict_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int H = (vict_pkg::imax(AW, BW) + 1) / 2;

    logic [2*H-1:0] w_a;
    logic [2*H-1:0] w_b;

    logic [2*H-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [2*H-1:0] n_p00, n_p01, n_p10, n_p11;
    logic [2*H:0]   r_mid, n_mid;
    logic [4*H-1:0] r_low, n_low;
    logic [4*H-1:0] r_prod, n_prod;

    assign w_a = (2*H)'(i_a);
    assign w_b = (2*H)'(i_b);

    always_comb begin
        n_p00 = w_a[H-1:0]   * w_b[H-1:0];
        n_p01 = w_a[H-1:0]   * w_b[2*H-1:H];
        n_p10 = w_a[2*H-1:H] * w_b[H-1:0];
        n_p11 = w_a[2*H-1:H] * w_b[2*H-1:H];
        n_mid = (2*H+1)'(r_p01) + (2*H+1)'(r_p10);
        n_low = {r_p11, r_p00};
        n_prod = r_low + {{(H-1){1'b0}}, r_mid, {H{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= n_p00;
            r_p01  <= n_p01;
            r_p10  <= n_p10;
            r_p11  <= n_p11;
            r_mid  <= n_mid;
            r_low  <= n_low;
            r_prod <= n_prod;
        end
    end

    assign o_p = r_prod[AW+BW-1:0];

endmodule

>>> design/vict_geom.sv
// ----------------------------------------------------------------------------
// vict_geom
// Front end: axis ordering, per-axis differences, squares and dot terms,
// their sums, and the operands for the wide multipliers. Four stages.
// ----------------------------------------------------------------------------
module vict_geom #(
    parameter int CB = vict_pkg::COORD_BITS_DEF,
    parameter int FB = vict_pkg::FRACTION_BITS_DEF,
    localparam int RB  = vict_pkg::RADIUS_BITS,
    localparam int SB  = vict_pkg::SLACK_BITS,
    localparam int SS  = vict_pkg::SCALE_SHIFT,
    localparam int DW  = CB + FB + 1,
    localparam int VW  = CB + 1,
    localparam int PW  = 2 * DW,
    localparam int HW  = 2 * CB + 2,
    localparam int DPW = DW + VW,
    localparam int DTW = DPW + 2,
    localparam int MW  = DTW - 1,
    localparam int RLW = vict_pkg::imax(2 * RB + SS, SB + 2 * FB) + 1,
    localparam int HSW = vict_pkg::imax(HW + SS, SB + 2 * FB) + 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CB-1:0] i_vox    [3],
    input  logic signed [CB-1:0] i_start  [3],
    input  logic signed [CB-1:0] i_finish [3],
    input  logic [RB-1:0]        i_radius,
    input  logic [SB-1:0]        i_slack,
    output logic [PW-1:0]        o_p,
    output logic [PW-1:0]        o_e,
    output logic [HW-1:0]        o_h2,
    output logic [HSW-1:0]       o_h2st,
    output logic [RLW-1:0]       o_r2lim,
    output logic [MW-1:0]        o_dmag,
    output logic                 o_zero
);

    // stage 1
    logic signed [VW-1:0]  r_s1_vh [3], n_s1_vh [3];
    logic signed [DW-1:0]  r_s1_pb [3], n_s1_pb [3];
    logic signed [DW-1:0]  r_s1_pe [3], n_s1_pe [3];
    // stage 2
    logic [HW-1:0]         r_s2_vh2 [3], n_s2_vh2 [3];
    logic signed [DPW-1:0] r_s2_dp  [3], n_s2_dp  [3];
    logic [PW-1:0]         r_s2_pp  [3], n_s2_pp  [3];
    logic [PW-1:0]         r_s2_ee  [3], n_s2_ee  [3];
    logic [2*RB-1:0]       r_s2_rad2, n_s2_rad2;
    // stage 3
    logic [HW-1:0]         r_s3_h2, n_s3_h2;
    logic signed [DTW-1:0] r_s3_dot, n_s3_dot;
    logic [PW-1:0]         r_s3_p, n_s3_p;
    logic [PW-1:0]         r_s3_e, n_s3_e;
    logic [RLW-1:0]        r_s3_r2lim, n_s3_r2lim;
    // stage 4
    logic [HW-1:0]         r_s4_h2, n_s4_h2;
    logic [HSW-1:0]        r_s4_h2st, n_s4_h2st;
    logic [MW-1:0]         r_s4_dmag, n_s4_dmag;
    logic [PW-1:0]         r_s4_p, n_s4_p;
    logic [PW-1:0]         r_s4_e, n_s4_e;
    logic [RLW-1:0]        r_s4_r2lim, n_s4_r2lim;
    logic                  r_s4_zero, n_s4_zero;

    always_comb begin
        logic signed [CB-1:0] lo;
        logic signed [CB-1:0] hi;
        logic signed [DW-1:0] v;
        for (int i = 0; i < 3; i++) begin
            lo = (i_start[i] < i_finish[i]) ? i_start[i] : i_finish[i];
            hi = (i_start[i] < i_finish[i]) ? i_finish[i] : i_start[i];
            v  = DW'(i_vox[i]) <<< FB;
            n_s1_vh[i] = VW'(hi) - VW'(lo);
            n_s1_pb[i] = v - DW'(lo);
            n_s1_pe[i] = v - DW'(hi);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s2_vh2[i] = HW'(r_s1_vh[i]) * HW'(r_s1_vh[i]);
            n_s2_dp[i]  = DPW'(r_s1_pb[i]) * DPW'(r_s1_vh[i]);
            n_s2_pp[i]  = PW'(r_s1_pb[i]) * PW'(r_s1_pb[i]);
            n_s2_ee[i]  = PW'(r_s1_pe[i]) * PW'(r_s1_pe[i]);
        end
        n_s2_rad2 = (2*RB)'(i_radius) * (2*RB)'(i_radius);
    end

    always_comb begin
        n_s3_h2    = r_s2_vh2[0] + r_s2_vh2[1] + r_s2_vh2[2];
        n_s3_dot   = DTW'(r_s2_dp[0]) + DTW'(r_s2_dp[1]) + DTW'(r_s2_dp[2]);
        n_s3_p     = r_s2_pp[0] + r_s2_pp[1] + r_s2_pp[2];
        n_s3_e     = r_s2_ee[0] + r_s2_ee[1] + r_s2_ee[2];
        n_s3_r2lim = (RLW'(r_s2_rad2) << SS) + (RLW'(i_slack) << (2 * FB));
    end

    always_comb begin
        n_s4_dmag  = r_s3_dot[DTW-1] ? MW'(-r_s3_dot) : MW'(r_s3_dot);
        n_s4_h2st  = (HSW'(r_s3_h2) << SS) + (HSW'(i_slack) << (2 * FB));
        n_s4_zero  = (r_s3_h2 == '0);
        n_s4_h2    = r_s3_h2;
        n_s4_p     = r_s3_p;
        n_s4_e     = r_s3_e;
        n_s4_r2lim = r_s3_r2lim;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_vh    <= n_s1_vh;
            r_s1_pb    <= n_s1_pb;
            r_s1_pe    <= n_s1_pe;
            r_s2_vh2   <= n_s2_vh2;
            r_s2_dp    <= n_s2_dp;
            r_s2_pp    <= n_s2_pp;
            r_s2_ee    <= n_s2_ee;
            r_s2_rad2  <= n_s2_rad2;
            r_s3_h2    <= n_s3_h2;
            r_s3_dot   <= n_s3_dot;
            r_s3_p     <= n_s3_p;
            r_s3_e     <= n_s3_e;
            r_s3_r2lim <= n_s3_r2lim;
            r_s4_h2    <= n_s4_h2;
            r_s4_h2st  <= n_s4_h2st;
            r_s4_dmag  <= n_s4_dmag;
            r_s4_p     <= n_s4_p;
            r_s4_e     <= n_s4_e;
            r_s4_r2lim <= n_s4_r2lim;
            r_s4_zero  <= n_s4_zero;
        end
    end

    assign o_p     = r_s4_p;
    assign o_e     = r_s4_e;
    assign o_h2    = r_s4_h2;
    assign o_h2st  = r_s4_h2st;
    assign o_r2lim = r_s4_r2lim;
    assign o_dmag  = r_s4_dmag;
    assign o_zero  = r_s4_zero;

endmodule

>>> design/vict_cmp.sv
// ----------------------------------------------------------------------------
// vict_cmp
// Back end: builds both right-hand sides, then the three limit compares and
// the result register. Two stages.
// ----------------------------------------------------------------------------
module vict_cmp #(
    parameter int DDW = 80,
    parameter int PHW = 80,
    parameter int L1W = 80,
    parameter int L2W = 80
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_zero,
    input  logic [DDW-1:0] i_d,
    input  logic [PHW-1:0] i_ph,
    input  logic [PHW-1:0] i_eh,
    input  logic [L1W-1:0] i_l1,
    input  logic [L2W-1:0] i_l2,
    output logic           o_inside
);

    localparam int SS = vict_pkg::SCALE_SHIFT;
    localparam int CW = vict_pkg::imax(vict_pkg::imax(DDW + SS, PHW + SS + 1),
                                       vict_pkg::imax(L1W, L2W)) + 1;

    logic [CW-1:0] r_rhs1, n_rhs1;
    logic [CW-1:0] r_rhs2, n_rhs2;
    logic [CW-1:0] r_ph, n_ph;
    logic [CW-1:0] r_pe, n_pe;
    logic          r_zero;
    logic          r_inside, n_inside;

    always_comb begin
        n_rhs1 = (CW'(i_d) << SS) + CW'(i_l1);
        n_rhs2 = (CW'(i_d) << SS) + CW'(i_l2);
        n_ph   = CW'(i_ph) << SS;
        n_pe   = (CW'(i_ph) + CW'(i_eh)) << SS;
    end

    // radial limit, then both end-cap limits
    always_comb begin
        n_inside = !r_zero && (r_ph <= r_rhs1) && ((r_ph << 1) <= r_rhs2)
                   && (r_pe <= r_rhs2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rhs1   <= n_rhs1;
            r_rhs2   <= n_rhs2;
            r_ph     <= n_ph;
            r_pe     <= n_pe;
            r_zero   <= i_zero;
            r_inside <= n_inside;
        end
    end

    assign o_inside = r_inside;

endmodule

>>> design/voxel_in_cylinder_test.sv
// ----------------------------------------------------------------------------
// voxel_in_cylinder_test
// Tests whether an integer voxel lies inside a configured cylinder, using
// exact integer compares scaled through by the squared axis length.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_voxel_x/y/z
//  out      | output    | o_out_valid / i_out_ready  | o_inside_res
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled; 4 front-end, 3 split multiplier,
// and 2 compare stages, set by the width of the exact products.
// Whole pipeline advances on one enable; a stalled output holds every stage.
// Reset (synchronous) empties the pipeline and clears the config registers to zero.
// Config is always ready; radius and slack are read in front-end stages 2 to 4,
// so writes belong only to an empty pipeline.
// ----------------------------------------------------------------------------
module voxel_in_cylinder_test #(
    parameter int COORD_BITS    = vict_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = vict_pkg::FRACTION_BITS_DEF,
    localparam int CFG_DW = vict_pkg::imax(COORD_BITS, vict_pkg::SLACK_BITS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_BITS-1:0]        i_voxel_x,
    input  logic signed [COORD_BITS-1:0]        i_voxel_y,
    input  logic signed [COORD_BITS-1:0]        i_voxel_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_inside_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vict_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]                   i_cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int RB    = vict_pkg::RADIUS_BITS;
    localparam int SB    = vict_pkg::SLACK_BITS;
    localparam int SS    = vict_pkg::SCALE_SHIFT;
    localparam int DEPTH = vict_pkg::PIPE_DEPTH;
    localparam int MS    = vict_pkg::MUL_STAGES;
    localparam int DW    = CB + FB + 1;
    localparam int PW    = 2 * DW;
    localparam int HW    = 2 * CB + 2;
    localparam int MW    = DW + CB + 2;
    localparam int RLW   = vict_pkg::imax(2 * RB + SS, SB + 2 * FB) + 1;
    localparam int HSW   = vict_pkg::imax(HW + SS, SB + 2 * FB) + 1;

    logic signed [CB-1:0] r_start  [3];
    logic signed [CB-1:0] r_finish [3];
    logic [RB-1:0]        r_radius;
    logic [SB-1:0]        r_slack;

    logic [DEPTH-1:0]     r_vld;
    logic [MS-1:0]        r_zero_d;
    logic                 w_en;
    logic signed [CB-1:0] w_vox [3];

    logic [PW-1:0]        w_p, w_e;
    logic [HW-1:0]        w_h2;
    logic [HSW-1:0]       w_h2st;
    logic [RLW-1:0]       w_r2lim;
    logic [MW-1:0]        w_dmag;
    logic                 w_zero;

    logic [2*MW-1:0]      w_d;
    logic [PW+HW-1:0]     w_ph, w_eh;
    logic [RLW+HW-1:0]    w_l1;
    logic [HSW+HW-1:0]    w_l2;

    assign w_en        = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[DEPTH-1];
    assign o_cfg_ready = 1'b1;

    assign w_vox[0] = i_voxel_x;
    assign w_vox[1] = i_voxel_y;
    assign w_vox[2] = i_voxel_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_start[i]  <= '0;
                r_finish[i] <= '0;
            end
            r_radius <= '0;
            r_slack  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (vict_pkg::t_cfg_idx'(i_cfg_index))
                vict_pkg::REG_START_X:  r_start[0]  <= i_cfg_data[CB-1:0];
                vict_pkg::REG_START_Y:  r_start[1]  <= i_cfg_data[CB-1:0];
                vict_pkg::REG_START_Z:  r_start[2]  <= i_cfg_data[CB-1:0];
                vict_pkg::REG_FINISH_X: r_finish[0] <= i_cfg_data[CB-1:0];
                vict_pkg::REG_FINISH_Y: r_finish[1] <= i_cfg_data[CB-1:0];
                vict_pkg::REG_FINISH_Z: r_finish[2] <= i_cfg_data[CB-1:0];
                vict_pkg::REG_RADIUS:   r_radius    <= i_cfg_data[RB-1:0];
                vict_pkg::REG_SLACK:    r_slack     <= i_cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // zero-axis flag rides alongside the multipliers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero_d <= {r_zero_d[MS-2:0], w_zero};
        end
    end

    vict_geom #(
        .CB (CB),
        .FB (FB)
    ) u_geom (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_vox    (w_vox),
        .i_start  (r_start),
        .i_finish (r_finish),
        .i_radius (r_radius),
        .i_slack  (r_slack),
        .o_p      (w_p),
        .o_e      (w_e),
        .o_h2     (w_h2),
        .o_h2st   (w_h2st),
        .o_r2lim  (w_r2lim),
        .o_dmag   (w_dmag),
        .o_zero   (w_zero)
    );

    vict_mul #(.AW (MW), .BW (MW)) u_mul_d (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_dmag), .i_b (w_dmag), .o_p (w_d)
    );

    vict_mul #(.AW (PW), .BW (HW)) u_mul_ph (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_p), .i_b (w_h2), .o_p (w_ph)
    );

    vict_mul #(.AW (PW), .BW (HW)) u_mul_eh (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_e), .i_b (w_h2), .o_p (w_eh)
    );

    vict_mul #(.AW (RLW), .BW (HW)) u_mul_l1 (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_r2lim), .i_b (w_h2), .o_p (w_l1)
    );

    vict_mul #(.AW (HSW), .BW (HW)) u_mul_l2 (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_h2st), .i_b (w_h2), .o_p (w_l2)
    );

    vict_cmp #(
        .DDW (2 * MW),
        .PHW (PW + HW),
        .L1W (RLW + HW),
        .L2W (HSW + HW)
    ) u_cmp (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_zero   (r_zero_d[MS-1]),
        .i_d      (w_d),
        .i_ph     (w_ph),
        .i_eh     (w_eh),
        .i_l1     (w_l1),
        .i_l2     (w_l2),
        .o_inside (o_inside_res)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pipeline not empty after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_degenerate_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_start[0] == r_finish[0]) && (r_start[1] == r_finish[1])
        && (r_start[2] == r_finish[2]) |-> !o_inside_res)
        else $error("inside reported for zero-length axis");

endmodule
